/* rtl/assert_macros.svh */
// Assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/arpc_pkg.sv */
package arpc_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b1;

	localparam logic [15:0] OP_REQUEST  = 16'd1;
	localparam logic [15:0] OP_REPLY    = 16'd2;
	localparam logic [7:0]  HW_LEN_ETH  = 8'd6;
	localparam logic [7:0]  PROTO_LEN_IP = 8'd4;

	typedef enum logic [2:0] {
		ST_ANSWERED = 3'd0,
		ST_IGNORED  = 3'd1,
		ST_LEARNED  = 3'd2,
		ST_UNKNOWN  = 3'd3,
		ST_LOOKUP   = 3'd4
	} status_t;

	typedef struct packed {
		logic capture;
		logic step;
		logic write;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_search;
		logic hit;
		logic search_end;
	} dp_sts_t;

endpackage

/* rtl/arpc_ctrl.sv */
module arpc_ctrl import arpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SEARCH = 4'b0010,
		S_UPDATE = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_vld_q;
	logic   accept;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_vld_q;

	always_comb begin
		cmd.capture = accept;
		cmd.step    = (state_q == S_SEARCH) && sts.need_search;
		cmd.write   = (state_q == S_UPDATE);
		cmd.load    = (state_q == S_DONE) && (!out_vld_q || !out_stall);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_nxt = S_SEARCH;
			end
			S_SEARCH: begin
				if (!sts.need_search) state_nxt = S_DONE;
				else if (sts.hit || sts.search_end) state_nxt = S_UPDATE;
			end
			S_UPDATE: begin
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (cmd.load) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) out_vld_q <= 1'b1;
			else if (!out_stall) out_vld_q <= 1'b0;
		end
	end

endmodule

/* rtl/arpc_dp.sv */
module arpc_dp import arpc_pkg::*; #(
	parameter int CACHE_ENTRIES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dp_sts_t               sts,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_type,
	input  logic [15:0]           hw_type,
	input  logic [15:0]           proto_type,
	input  logic [7:0]            hw_len,
	input  logic [7:0]            proto_len,
	input  logic [15:0]           operation,
	input  logic [47:0]           sender_mac,
	input  logic [31:0]           sender_ip,
	input  logic [31:0]           target_ip,
	output logic [2:0]            status,
	output logic                  send_reply,
	output logic [15:0]           reply_hw_type,
	output logic [15:0]           reply_proto_type,
	output logic [47:0]           reply_dest_mac,
	output logic [31:0]           reply_dest_ip,
	output logic                  lookup_hit,
	output logic [47:0]           lookup_mac
);

	localparam int IDXW = $clog2(CACHE_ENTRIES);
	localparam int CNTW = $clog2(CACHE_ENTRIES + 1);
	localparam logic [CNTW-1:0] FULL     = CNTW'(CACHE_ENTRIES);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CACHE_ENTRIES - 1);

	logic [31:0] own_ip_q;

	// captured transaction
	logic        req_type_q;
	logic [15:0] hw_type_q, proto_type_q, operation_q;
	logic [7:0]  hw_len_q, proto_len_q;
	logic [47:0] sender_mac_q;
	logic [31:0] sender_ip_q, target_ip_q;

	logic [31:0] mem_ip  [CACHE_ENTRIES];
	logic [47:0] mem_mac [CACHE_ENTRIES];

	logic [CNTW-1:0] count_q, cnt_q;
	logic [IDXW-1:0] head_q, slot_q, rd_addr_s1, wr_addr;
	logic            rd_vld_s1, found_q;
	logic [31:0]     rd_ip_s1;
	logic [47:0]     rd_mac_s1, found_mac_q;

	logic    req_ok, is_lookup, is_learn, issue, hit_now, wr_en, not_full;
	logic [31:0] key;
	status_t code;

	status_t     status_q;
	logic        send_reply_q, lookup_hit_q;
	logic [15:0] reply_hw_type_q, reply_proto_type_q;
	logic [47:0] reply_dest_mac_q, lookup_mac_q;
	logic [31:0] reply_dest_ip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
		end else if (cfg_we && cfg_idx == REG_OWN_IP) begin
			own_ip_q <= cfg_data[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q   <= req_type;
			hw_type_q    <= hw_type;
			proto_type_q <= proto_type;
			hw_len_q     <= hw_len;
			proto_len_q  <= proto_len;
			operation_q  <= operation;
			sender_mac_q <= sender_mac;
			sender_ip_q  <= sender_ip;
			target_ip_q  <= target_ip;
		end
	end

	always_comb begin
		req_ok = (operation_q == OP_REQUEST) && (hw_len_q == HW_LEN_ETH) &&
			(proto_len_q == PROTO_LEN_IP) && (target_ip_q == own_ip_q);
		is_lookup = req_type_q;
		is_learn  = !req_type_q && ((operation_q == OP_REPLY) || req_ok);
		if (is_lookup) code = ST_LOOKUP;
		else if (operation_q == OP_REQUEST) code = req_ok ? ST_ANSWERED : ST_IGNORED;
		else if (operation_q == OP_REPLY) code = ST_LEARNED;
		else code = ST_UNKNOWN;
		key = is_lookup ? target_ip_q : sender_ip_q;
	end

	// search: one read issued per cycle, compared the cycle after
	assign issue   = cmd.step && (cnt_q < count_q);
	assign hit_now = rd_vld_s1 && (rd_ip_s1 == key);

	always_comb begin
		sts.need_search = is_lookup || is_learn;
		sts.hit         = hit_now;
		sts.search_end  = (cnt_q == count_q) && !rd_vld_s1;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_ip_s1   <= mem_ip[cnt_q[IDXW-1:0]];
			rd_mac_s1  <= mem_mac[cnt_q[IDXW-1:0]];
			rd_addr_s1 <= cnt_q[IDXW-1:0];
		end
		if (hit_now) begin
			slot_q      <= rd_addr_s1;
			found_mac_q <= rd_mac_s1;
		end
	end

	// head stays at zero until the cache first fills; then it marks the oldest entry
	assign not_full = (count_q < FULL);
	assign wr_en    = cmd.write && is_learn;
	assign wr_addr  = found_q ? slot_q : (not_full ? count_q[IDXW-1:0] : head_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_ip[wr_addr]  <= sender_ip_q;
			mem_mac[wr_addr] <= sender_mac_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			head_q    <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.capture) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (issue) cnt_q <= cnt_q + CNTW'(1);
				if (hit_now) found_q <= 1'b1;
			end
			if (wr_en && !found_q) begin
				if (not_full) count_q <= count_q + CNTW'(1);
				else head_q <= (head_q == LAST_IDX) ? '0 : head_q + IDXW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q           <= code;
			send_reply_q       <= (code == ST_ANSWERED);
			reply_hw_type_q    <= (code == ST_ANSWERED) ? hw_type_q : '0;
			reply_proto_type_q <= (code == ST_ANSWERED) ? proto_type_q : '0;
			reply_dest_mac_q   <= (code == ST_ANSWERED) ? sender_mac_q : '0;
			reply_dest_ip_q    <= (code == ST_ANSWERED) ? sender_ip_q : '0;
			lookup_hit_q       <= is_lookup && found_q;
			lookup_mac_q       <= (is_lookup && found_q) ? found_mac_q : '0;
		end
	end

	assign status           = status_q;
	assign send_reply       = send_reply_q;
	assign reply_hw_type    = reply_hw_type_q;
	assign reply_proto_type = reply_proto_type_q;
	assign reply_dest_mac   = reply_dest_mac_q;
	assign reply_dest_ip    = reply_dest_ip_q;
	assign lookup_hit       = lookup_hit_q;
	assign lookup_mac       = lookup_mac_q;

endmodule

/* rtl/arp_responder_cache.sv */
// ARP responder with address cache, one transaction at a time.
// Lookups and learns run a serial cache search, one entry per cycle through the registered
// memory read; ignored or unknown packets skip the search. The next accept can come in the
// cycle after the result is loaded.
// Reset (arst_n low, asynchronous) empties the cache and clears own_ip; no clearing pass.
module arp_responder_cache import arpc_pkg::*; #(
	parameter int CACHE_ENTRIES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [15:0]           hw_type,
	input  logic [15:0]           proto_type,
	input  logic [7:0]            hw_len,
	input  logic [7:0]            proto_len,
	input  logic [15:0]           operation,
	input  logic [47:0]           sender_mac,
	input  logic [31:0]           sender_ip,
	input  logic [31:0]           target_ip,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            status,
	output logic                  send_reply,
	output logic [15:0]           reply_hw_type,
	output logic [15:0]           reply_proto_type,
	output logic [47:0]           reply_dest_mac,
	output logic [31:0]           reply_dest_ip,
	output logic                  lookup_hit,
	output logic [47:0]           lookup_mac
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	arpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	arpc_dp #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_data         (cfg_data),
		.req_type         (req_type),
		.hw_type          (hw_type),
		.proto_type       (proto_type),
		.hw_len           (hw_len),
		.proto_len        (proto_len),
		.operation        (operation),
		.sender_mac       (sender_mac),
		.sender_ip        (sender_ip),
		.target_ip        (target_ip),
		.status           (status),
		.send_reply       (send_reply),
		.reply_hw_type    (reply_hw_type),
		.reply_proto_type (reply_proto_type),
		.reply_dest_mac   (reply_dest_mac),
		.reply_dest_ip    (reply_dest_ip),
		.lookup_hit       (lookup_hit),
		.lookup_mac       (lookup_mac)
	);

endmodule

/* rtl/arpc_checker.sv */
`include "assert_macros.svh"

module arpc_checker import arpc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic        send_reply,
	input logic        lookup_hit,
	input logic [47:0] lookup_mac
);

	// one transaction in flight: an accept is always followed by a stall
	`ASSERT_NXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall)

	// a lookup result never asks for a reply, other results never report a hit
	`ASSERT_IMP(a_hit_only_lookup, clk, arst_n, out_valid && status != ST_LOOKUP, !lookup_hit && lookup_mac == '0)
	`ASSERT_IMP(a_reply_only_answer, clk, arst_n, out_valid && send_reply, status == ST_ANSWERED)

	// stalled result holds
	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(lookup_mac))

endmodule

bind arp_responder_cache arpc_checker u_arpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.send_reply (send_reply),
	.lookup_hit (lookup_hit),
	.lookup_mac (lookup_mac)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import arpc_pkg::*;

	localparam int CACHE_DEPTH = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_SIZE   = 12;

	typedef struct packed {
		logic        req_type;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_len;
		logic [7:0]  proto_len;
		logic [15:0] operation;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
	} arp_txn_t;

	typedef struct packed {
		status_t     status;
		logic        send_reply;
		logic [15:0] echo_hw_type;
		logic [15:0] echo_proto_type;
		logic [47:0] dest_mac;
		logic [31:0] dest_ip;
		logic        hit;
		logic [47:0] found_mac;
	} arp_res_t;

	typedef struct packed {
		arp_txn_t txn;
		logic     fixed;
		arp_res_t res;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  req_type = 1'b0;
	logic [15:0]           hw_type = '0;
	logic [15:0]           proto_type = '0;
	logic [7:0]            hw_len = '0;
	logic [7:0]            proto_len = '0;
	logic [15:0]           operation = '0;
	logic [47:0]           sender_mac = '0;
	logic [31:0]           sender_ip = '0;
	logic [31:0]           target_ip = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            status;
	logic                  send_reply;
	logic [15:0]           reply_hw_type;
	logic [15:0]           reply_proto_type;
	logic [47:0]           reply_dest_mac;
	logic [31:0]           reply_dest_ip;
	logic                  lookup_hit;
	logic [47:0]           lookup_mac;

	// station address and cache as the block should hold them
	logic [31:0] station_ip = '0;
	logic [31:0] cache_ip [CACHE_DEPTH];
	logic [47:0] cache_mac [CACHE_DEPTH];
	int          cache_cnt = 0;
	int          evictions = 0;

	arp_res_t    pending_res [$];
	logic [31:0] ip_pool [POOL_SIZE];
	int          fails = 0;
	int          cycles = 0;
	int          seen [5];
	int          hits = 0;
	int          checked = 0;
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;

	arp_responder_cache #(
		.CACHE_ENTRIES(CACHE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.hw_type(hw_type),
		.proto_type(proto_type),
		.hw_len(hw_len),
		.proto_len(proto_len),
		.operation(operation),
		.sender_mac(sender_mac),
		.sender_ip(sender_ip),
		.target_ip(target_ip),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.send_reply(send_reply),
		.reply_hw_type(reply_hw_type),
		.reply_proto_type(reply_proto_type),
		.reply_dest_mac(reply_dest_mac),
		.reply_dest_ip(reply_dest_ip),
		.lookup_hit(lookup_hit),
		.lookup_mac(lookup_mac)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("%0t: timed out with %0d results outstanding", $time, pending_res.size());
		$display("[arp_responder_cache] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int cache_find(logic [31:0] ip);
		for (int i = 0; i < cache_cnt; i++) begin
			if (cache_ip[i] == ip)
				return i;
		end
		return -1;
	endfunction

	function automatic void cache_learn(logic [31:0] ip, logic [47:0] mac);
		int s;
		s = cache_find(ip);
		if (s >= 0) begin
			cache_mac[s] = mac;
		end else if (cache_cnt < CACHE_DEPTH) begin
			cache_ip[cache_cnt] = ip;
			cache_mac[cache_cnt] = mac;
			cache_cnt++;
		end else begin
			// full: oldest entry drops out, rest move down whole
			for (int i = 0; i < CACHE_DEPTH - 1; i++) begin
				cache_ip[i] = cache_ip[i + 1];
				cache_mac[i] = cache_mac[i + 1];
			end
			cache_ip[CACHE_DEPTH - 1] = ip;
			cache_mac[CACHE_DEPTH - 1] = mac;
			evictions++;
		end
	endfunction

	function automatic arp_res_t arp_predict(arp_txn_t t);
		arp_res_t r;
		int s;
		r = '0;
		if (t.req_type) begin
			s = cache_find(t.target_ip);
			r.status = ST_LOOKUP;
			if (s >= 0) begin
				r.hit = 1'b1;
				r.found_mac = cache_mac[s];
			end
		end else if (t.operation == OP_REQUEST) begin
			if (t.hw_len == HW_LEN_ETH && t.proto_len == PROTO_LEN_IP &&
					t.target_ip == station_ip) begin
				cache_learn(t.sender_ip, t.sender_mac);
				r.status = ST_ANSWERED;
				r.send_reply = 1'b1;
				r.echo_hw_type = t.hw_type;
				r.echo_proto_type = t.proto_type;
				r.dest_mac = t.sender_mac;
				r.dest_ip = t.sender_ip;
			end else begin
				r.status = ST_IGNORED;
			end
		end else if (t.operation == OP_REPLY) begin
			cache_learn(t.sender_ip, t.sender_mac);
			r.status = ST_LEARNED;
		end else begin
			r.status = ST_UNKNOWN;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic arp_txn_t pkt(logic rq, logic [15:0] op, logic [7:0] hl, logic [7:0] pl,
			logic [15:0] hw, logic [15:0] pt, logic [47:0] smac, logic [31:0] sip,
			logic [31:0] tip);
		arp_txn_t t;
		t.req_type = rq;
		t.operation = op;
		t.hw_len = hl;
		t.proto_len = pl;
		t.hw_type = hw;
		t.proto_type = pt;
		t.sender_mac = smac;
		t.sender_ip = sip;
		t.target_ip = tip;
		return t;
	endfunction

	function automatic arp_res_t plain(status_t st, logic hit, logic [47:0] mac);
		arp_res_t r;
		r = '0;
		r.status = st;
		r.hit = hit;
		r.found_mac = mac;
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic arp_txn_t rand_txn();
		arp_txn_t t;
		logic [63:0] a, b, c;
		int k;
		a = {$urandom(), $urandom()};
		b = {$urandom(), $urandom()};
		c = {$urandom(), $urandom()};
		t = pkt(b[48], a[63:48], a[39:32], a[47:40], a[15:0], a[31:16], b[47:0], c[31:0],
			c[63:32]);
		k = $urandom_range(0, 99);
		if (k < 30) begin
			t.req_type = 1'b0;
			t.operation = OP_REQUEST;
			t.hw_len = HW_LEN_ETH;
			t.proto_len = PROTO_LEN_IP;
			t.target_ip = station_ip;
			t.sender_ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
		end else if (k < 50) begin
			t.req_type = 1'b0;
			t.operation = OP_REPLY;
			t.sender_ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
		end else if (k < 75) begin
			t.req_type = 1'b1;
			if ($urandom_range(0, 3) != 0)
				t.target_ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
		end else if (k < 87) begin
			// request spoilt in one field only
			t.req_type = 1'b0;
			t.operation = OP_REQUEST;
			t.hw_len = HW_LEN_ETH;
			t.proto_len = PROTO_LEN_IP;
			t.target_ip = station_ip;
			t.sender_ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
			case ($urandom_range(0, 2))
				0: t.hw_len = b[63:56];
				1: t.proto_len = b[63:56];
				default: t.target_ip = c[63:32];
			endcase
		end
		return t;
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic set_station(logic [31:0] ip, logic [47:0] mac);
		cfg_we <= 1'b1;
		cfg_idx <= REG_OWN_IP;
		cfg_data <= {16'h0000, ip};
		@(posedge clk);
		cfg_idx <= REG_OWN_MAC;
		cfg_data <= mac;
		@(posedge clk);
		cfg_we <= 1'b0;
		station_ip = ip;
	endtask

	task automatic offer(arp_txn_t t, logic fixed, arp_res_t fixed_res);
		int g;
		arp_res_t r;
		g = calm ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_type <= t.req_type;
		hw_type <= t.hw_type;
		proto_type <= t.proto_type;
		hw_len <= t.hw_len;
		proto_len <= t.proto_len;
		operation <= t.operation;
		sender_mac <= t.sender_mac;
		sender_ip <= t.sender_ip;
		target_ip <= t.target_ip;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		r = arp_predict(t);
		pending_res.push_back(fixed ? fixed_res : r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic run_random(int n_items, bit squeeze);
		ip_pool[0] = 32'h0000_0000;
		ip_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			ip_pool[i] = $urandom();
		for (int i = 0; i < n_items; i++) begin
			calm = (i % 100) < 25;
			if (squeeze && i == 60)
				hold_req = 1'b1;
			offer(rand_txn(), 1'b0, '0);
		end
		calm = 1'b0;
	endtask

	// ---------------------------------------------------------------- receiver

	initial begin
		int r;
		int run;
		int hold_left;
		run = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				// long hold-off so the block backs up into its input
				hold_req = 1'b0;
				hold_left = 300;
				out_stall <= 1'b1;
			end else if (run > 0) begin
				run--;
				out_stall <= 1'b1;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					out_stall <= 1'b0;
				end else begin
					run = gap_len();
					out_stall <= 1'b1;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			fails++;
		end
	endfunction

	always @(posedge clk) begin : check_out
		arp_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected transaction, status %0d", $time, status);
				fails++;
			end else begin
				e = pending_res.pop_front();
				check_field("status", 48'(e.status), 48'(status));
				check_field("send_reply", 48'(e.send_reply), 48'(send_reply));
				check_field("reply_hw_type", 48'(e.echo_hw_type), 48'(reply_hw_type));
				check_field("reply_proto_type", 48'(e.echo_proto_type),
					48'(reply_proto_type));
				check_field("reply_dest_mac", e.dest_mac, reply_dest_mac);
				check_field("reply_dest_ip", 48'(e.dest_ip), 48'(reply_dest_ip));
				check_field("lookup_hit", 48'(e.hit), 48'(lookup_hit));
				check_field("lookup_mac", e.found_mac, lookup_mac);
			end
			checked++;
			if (status <= 3'(ST_LOOKUP))
				seen[status]++;
			if (status == 3'(ST_LOOKUP) && lookup_hit)
				hits++;
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		dir_row_t dir_rows [25];
		logic [31:0] own;
		own = 32'h0A00_0001;
		dir_rows[0] = '{pkt(1'b1, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0, 48'h0, 32'h0,
			32'h0A00_0002), 1'b1, plain(ST_LOOKUP, 1'b0, 48'h0)};
		dir_rows[1] = '{pkt(1'b0, OP_REQUEST, HW_LEN_ETH, PROTO_LEN_IP, 16'hFFFF, 16'h0000,
			48'hFFFF_FFFF_FFFF, 32'h0A00_0002, own), 1'b0, '0};
		dir_rows[2] = '{pkt(1'b1, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0, 48'h0, 32'h0,
			32'h0A00_0002), 1'b1, plain(ST_LOOKUP, 1'b1, 48'hFFFF_FFFF_FFFF)};
		dir_rows[3] = '{pkt(1'b0, OP_REQUEST, 8'd5, PROTO_LEN_IP, 16'h0001, 16'h0800,
			48'h0200_0000_0003, 32'h0A00_0003, own), 1'b1, plain(ST_IGNORED, 1'b0, 48'h0)};
		dir_rows[4] = '{pkt(1'b0, OP_REQUEST, HW_LEN_ETH, 8'hFF, 16'h0001, 16'h0800,
			48'h0200_0000_0003, 32'h0A00_0003, own), 1'b1, plain(ST_IGNORED, 1'b0, 48'h0)};
		dir_rows[5] = '{pkt(1'b0, OP_REQUEST, HW_LEN_ETH, PROTO_LEN_IP, 16'h0001, 16'h0800,
			48'h0200_0000_0003, 32'h0A00_0003, 32'h0A00_0009), 1'b1,
			plain(ST_IGNORED, 1'b0, 48'h0)};
		dir_rows[6] = '{pkt(1'b0, 16'h0000, HW_LEN_ETH, PROTO_LEN_IP, 16'h0001, 16'h0800,
			48'h0200_0000_0004, 32'h0A00_0004, own), 1'b1, plain(ST_UNKNOWN, 1'b0, 48'h0)};
		dir_rows[7] = '{pkt(1'b0, 16'h0003, HW_LEN_ETH, PROTO_LEN_IP, 16'h0001, 16'h0800,
			48'h0200_0000_0004, 32'h0A00_0004, own), 1'b1, plain(ST_UNKNOWN, 1'b0, 48'h0)};
		dir_rows[8] = '{pkt(1'b0, 16'hFFFF, HW_LEN_ETH, PROTO_LEN_IP, 16'h0001, 16'h0800,
			48'h0200_0000_0004, 32'h0A00_0004, own), 1'b1, plain(ST_UNKNOWN, 1'b0, 48'h0)};
		dir_rows[9] = '{pkt(1'b0, OP_REPLY, 8'hFF, 8'h00, 16'h0000, 16'hFFFF, 48'h0,
			32'hFFFF_FFFF, 32'h0), 1'b1, plain(ST_LEARNED, 1'b0, 48'h0)};
		dir_rows[10] = '{pkt(1'b0, OP_REPLY, HW_LEN_ETH, PROTO_LEN_IP, 16'h0001, 16'h0800,
			48'h1234_5678_9ABC, 32'h0A00_0002, own), 1'b1, plain(ST_LEARNED, 1'b0, 48'h0)};
		dir_rows[11] = '{pkt(1'b1, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0, 48'h0, 32'h0,
			32'h0A00_0002), 1'b1, plain(ST_LOOKUP, 1'b1, 48'h1234_5678_9ABC)};
		// six more replies fill the cache to the brim
		for (int i = 0; i < 6; i++)
			dir_rows[12 + i] = '{pkt(1'b0, OP_REPLY, HW_LEN_ETH, PROTO_LEN_IP, 16'h0001,
				16'h0800, 48'h0200_0000_0010 + 48'(i), 32'h0A00_0010 + 32'(i), own),
				1'b0, '0};
		dir_rows[18] = '{pkt(1'b0, OP_REQUEST, HW_LEN_ETH, PROTO_LEN_IP, 16'h0000, 16'hFFFF,
			48'h0200_0000_0020, 32'h0A00_0020, own), 1'b0, '0};
		dir_rows[19] = '{pkt(1'b1, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0, 48'h0, 32'h0,
			32'h0A00_0002), 1'b1, plain(ST_LOOKUP, 1'b0, 48'h0)};
		dir_rows[20] = '{pkt(1'b1, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0, 48'h0, 32'h0,
			32'hFFFF_FFFF), 1'b1, plain(ST_LOOKUP, 1'b1, 48'h0)};
		dir_rows[21] = '{pkt(1'b1, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0, 48'h0, 32'h0,
			32'h0A00_0020), 1'b0, '0};
		// lookup carrying a well-formed request: must not learn anything
		dir_rows[22] = '{pkt(1'b1, OP_REQUEST, HW_LEN_ETH, PROTO_LEN_IP, 16'hFFFF, 16'hFFFF,
			48'hFFFF_FFFF_FFFF, 32'h0A00_00FF, 32'h0A00_0010), 1'b0, '0};
		dir_rows[23] = '{pkt(1'b1, 16'h0, 8'h0, 8'h0, 16'h0, 16'h0, 48'h0, 32'h0,
			32'h0A00_00FF), 1'b1, plain(ST_LOOKUP, 1'b0, 48'h0)};
		dir_rows[24] = '{pkt(1'b0, OP_REQUEST, HW_LEN_ETH, PROTO_LEN_IP, 16'h0, 16'h0, 48'h0,
			32'h0, own), 1'b0, '0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_station(own, 48'h02AB_CDEF_0001);
		foreach (dir_rows[i])
			offer(dir_rows[i].txn, dir_rows[i].fixed, dir_rows[i].res);
		drain();

		set_station(32'h0000_0000, 48'hFFFF_FFFF_FFFF);
		run_random(180, 1'b1);
		drain();
		set_station(32'hFFFF_FFFF, 48'h0000_0000_0000);
		run_random(180, 1'b0);
		drain();
		set_station($urandom(), 48'({$urandom(), $urandom()}));
		run_random(180, 1'b0);
		drain();
		set_station($urandom(), 48'({$urandom(), $urandom()}));
		run_random(185, 1'b0);
		drain();

		$display("%0d transactions checked: %0d answered, %0d ignored, %0d learned,",
			checked, seen[0], seen[1], seen[2]);
		$display("%0d unknown op, %0d lookups (%0d hits), %0d evictions, 5 station settings",
			seen[3], seen[4], hits, evictions);
		if (fails == 0)
			$display("[arp_responder_cache] OK");
		else
			$display("[arp_responder_cache] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_ctrl.sv
rtl/arpc_dp.sv
rtl/arp_responder_cache.sv
rtl/arpc_checker.sv
tb/sv/testbench.sv
